[hw/rtl/fubf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fubf_pkg
// Types shared by the first unique byte finder and its count table.
// ----------------------------------------------------------------------------
package fubf_pkg;

    localparam int unsigned CHAR_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } fubf_state_t;

    // Control from the sequencer to the count table.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } fubf_tbl_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/fubf_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fubf_table
// Count and first-position table. A flop per entry marks "seen at least
// once"; the memory word holds a "seen again" bit and the latest position.
// ----------------------------------------------------------------------------
module fubf_table
    import fubf_pkg::*;
#(
    parameter int unsigned ALPHABET = 256,
    parameter int unsigned POS_W    = 12
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fubf_tbl_ctrl_t              ctrl,
    input  wire logic [$clog2(ALPHABET)-1:0] wr_addr,
    input  wire logic [POS_W-1:0]            wr_pos,
    input  wire logic [$clog2(ALPHABET)-1:0] rd_addr,
    output logic                             rd_seen,
    output logic                             rd_many,
    output logic [POS_W-1:0]                 rd_pos
);

    logic [ALPHABET-1:0] seen_reg;
    logic [POS_W:0]      mem [ALPHABET];
    logic [POS_W:0]      rd_word_reg;
    logic                rd_seen_reg;

    // A second occurrence only needs the "many" bit; its position is never read.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= {seen_reg[wr_addr], wr_pos};
        end
        if (ctrl.rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            rd_seen_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                seen_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                seen_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_seen_reg <= seen_reg[rd_addr];
            end
        end
    end

    assign rd_seen = rd_seen_reg;
    assign rd_many = rd_word_reg[POS_W];
    assign rd_pos  = rd_word_reg[POS_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/first_unique_byte_finder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_unique_byte_finder_top
// Finds the first byte of a zero-terminated string that occurs exactly once.
// ----------------------------------------------------------------------------
// Each nonzero byte accepted while idle is one transaction: it writes the
// byte's entry in the count table and advances the position counter. The zero
// terminator starts a scan that reads the table one entry per cycle through
// its single read port, keeping the earliest entry counted exactly once in one
// shared comparator; the input is then held off through the scan of all
// ALPHABET entries, the drain state for the last compare and the hand-off to the
// output register, which waits while the previous result is not yet taken. The
// output register lets the next string start while a result waits. Bytes at
// or above ALPHABET advance the position but are not counted. Beyond MAX_LEN
// bytes new first positions saturate at MAX_LEN-1 and too_long is reported;
// ties go to the smaller byte.
module first_unique_byte_finder_top
    import fubf_pkg::*;
#(
    parameter int unsigned MAX_LEN  = 4096,
    parameter int unsigned ALPHABET = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] result_char
    output logic [1:0]       m_axis_tuser    // [0] found, [1] too_long
);

    localparam int unsigned IDX_W = $clog2(ALPHABET);
    localparam int unsigned POS_W = $clog2(MAX_LEN);
    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

    fubf_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     pos_cnt_reg, pos_cnt_next;
    logic                 overflow_reg, overflow_next;
    logic [IDX_W-1:0]     scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]     cmp_addr_reg, cmp_addr_next;
    logic                 cmp_pend_reg, cmp_pend_next;
    logic                 hit_reg, hit_next;
    logic [POS_W-1:0]     best_pos_reg, best_pos_next;
    logic [IDX_W-1:0]     best_val_reg, best_val_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_long_reg, out_long_next;

    fubf_tbl_ctrl_t       tbl_ctrl;
    logic                 tbl_seen;
    logic                 tbl_many;
    logic [POS_W-1:0]     tbl_pos;
    logic [POS_W-1:0]     cur_pos;

    logic                 in_fire;
    logic                 is_term;
    logic                 in_alpha;
    logic                 saturated;
    logic                 scan_last;
    logic                 out_free;
    logic                 load_out;
    logic                 take;

    fubf_table #(
        .ALPHABET (ALPHABET),
        .POS_W    (POS_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tbl_ctrl),
        .wr_addr (s_axis_tdata[IDX_W-1:0]),
        .wr_pos  (cur_pos),
        .rd_addr (scan_addr_reg),
        .rd_seen (tbl_seen),
        .rd_many (tbl_many),
        .rd_pos  (tbl_pos)
    );

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign is_term   = (s_axis_tdata == '0);
    assign in_alpha  = ({1'b0, s_axis_tdata} < 9'(ALPHABET));
    assign saturated = (pos_cnt_reg >= CNT_W'(MAX_LEN));
    assign cur_pos   = saturated ? POS_W'(MAX_LEN - 1) : pos_cnt_reg[POS_W-1:0];
    assign scan_last = (scan_addr_reg == IDX_W'(ALPHABET - 1));
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Shared comparator: the entry read last cycle against the best so far.
    assign take = cmp_pend_reg && tbl_seen && !tbl_many
                  && (!hit_reg || (tbl_pos < best_pos_reg));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_term)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready  = 1'b0;
        tbl_ctrl       = '0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                tbl_ctrl.wr_en = in_fire && !is_term && in_alpha;
            end
            ST_SCAN:
            begin
                tbl_ctrl.rd_en = 1'b1;
            end
            ST_FLUSH:
            begin
            end
            ST_DONE:
            begin
                load_out       = out_free;
                tbl_ctrl.clear = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        pos_cnt_next   = pos_cnt_reg;
        overflow_next  = overflow_reg;
        scan_addr_next = scan_addr_reg;
        cmp_addr_next  = scan_addr_reg;
        cmp_pend_next  = tbl_ctrl.rd_en;
        hit_next       = hit_reg;
        best_pos_next  = best_pos_reg;
        best_val_next  = best_val_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_found_next = out_found_reg;
        out_long_next  = out_long_reg;

        if (in_fire && !is_term)
        begin
            if (saturated)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                pos_cnt_next = pos_cnt_reg + CNT_W'(1);
            end
        end

        if (in_fire && is_term)
        begin
            scan_addr_next = '0;
            hit_next       = 1'b0;
            best_pos_next  = '1;
            best_val_next  = '0;
        end
        else if (tbl_ctrl.rd_en)
        begin
            scan_addr_next = scan_addr_reg + IDX_W'(1);
        end

        if (take)
        begin
            hit_next      = 1'b1;
            best_pos_next = tbl_pos;
            best_val_next = cmp_addr_reg;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_char_next  = CHAR_W'(best_val_reg);
            out_found_next = hit_reg;
            out_long_next  = overflow_reg;
            pos_cnt_next   = '0;
            overflow_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_cnt_reg   <= '0;
            overflow_reg  <= 1'b0;
            scan_addr_reg <= '0;
            cmp_pend_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            best_pos_reg  <= '1;
            best_val_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_cnt_reg   <= pos_cnt_next;
            overflow_reg  <= overflow_next;
            scan_addr_reg <= scan_addr_next;
            cmp_pend_reg  <= cmp_pend_next;
            hit_reg       <= hit_next;
            best_pos_reg  <= best_pos_next;
            best_val_reg  <= best_val_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg  <= cmp_addr_next;
        out_char_reg  <= out_char_next;
        out_found_reg <= out_found_next;
        out_long_reg  <= out_long_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = {out_long_reg, out_found_reg};

    // The table is never written while a scan or hand-off is under way.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !tbl_ctrl.wr_en)
        else $error("count table written outside idle");

    // The position counter saturates at MAX_LEN.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_cnt_reg <= CNT_W'(MAX_LEN))
        else $error("position counter beyond MAX_LEN");

    // A finished scan always presents its result on the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_axis_tvalid && (m_axis_tuser[0] == $past(hit_reg))))
        else $error("scan result not presented");

    // A compare is pending in the cycle after each table read.
    a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ctrl.rd_en |=> cmp_pend_reg)
        else $error("table read without compare");

endmodule

`default_nettype wire
